### rtl/core/kett_pkg.sv
// shared types and constants of the keyed expiry timer table
package kett_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TICK_W  = 16;
  localparam int KEY_W   = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [KEY_W-1:0]   timer_key;
    logic [TICK_W-1:0]  elapsed_ticks;
    logic [TICK_W-1:0]  duration;
    logic [TICK_W-1:0]  start_ticks;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               found;
    logic               table_full;
    logic [TICK_W-1:0]  accumulated;
    logic [TICK_W-1:0]  entry_duration;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TICK_W-1:0]  acc;
    logic [TICK_W-1:0]  limit;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               load;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               commit;
  } cmd_t;

  typedef struct packed {
    logic               out_free;
  } status_t;

endpackage

### rtl/core/kett_if.sv
// valid/ready channels for request and result items
interface kett_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] timer_key;
  logic [15:0] elapsed_ticks;
  logic [15:0] duration;
  logic [15:0] start_ticks;

  modport source (output valid, output opcode, output timer_key, output elapsed_ticks,
                  output duration, output start_ticks, input ready);
  modport sink   (input valid, input opcode, input timer_key, input elapsed_ticks,
                  input duration, input start_ticks, output ready);
endinterface

interface kett_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        found;
  logic        table_full;
  logic [15:0] accumulated;
  logic [15:0] entry_duration;

  modport source (output valid, output accepted, output found, output table_full,
                  output accumulated, output entry_duration, input ready);
  modport sink   (input valid, input accepted, input found, input table_full,
                  input accumulated, input entry_duration, output ready);
endinterface

### rtl/core/kett_ram.sv
// generic single write port, single read port ram with registered read
module kett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/kett_ctrl.sv
// sequencer: accept, scan every entry, drain the last read, then commit the result item
module kett_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kett_pkg::status_t st,
  output kett_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t                     state;
  logic [kett_pkg::IDX_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == kett_pkg::IDX_W'(kett_pkg::ENTRIES - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          // hold while the previous result item is still waiting
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign cmd.load    = (state == S_IDLE) && in_valid;
  assign cmd.rd_en   = (state == S_SCAN);
  assign cmd.rd_addr = cnt;
  assign cmd.commit  = (state == S_COMMIT);

endmodule

### rtl/core/kett_dp.sv
// datapath: entry storage, live bits, scan checks, commit and result register
module kett_dp (
  input  logic              clk,
  input  logic              rst,
  input  kett_pkg::cmd_t    cmd,
  output kett_pkg::status_t st,
  input  kett_pkg::item_t   item_in,
  output logic              out_valid,
  input  logic              out_ready,
  output kett_pkg::result_t result
);

  kett_pkg::item_t              item;
  logic [kett_pkg::ENTRIES-1:0] live;

  logic                         chk_valid;
  logic [kett_pkg::IDX_W-1:0]   chk_idx;

  logic                         match_hit;
  logic [kett_pkg::IDX_W-1:0]   match_idx;
  logic                         free_hit;
  logic [kett_pkg::IDX_W-1:0]   free_idx;
  logic [kett_pkg::TICK_W-1:0]  q_acc;
  logic [kett_pkg::TICK_W-1:0]  q_dur;

  kett_pkg::entry_t             rd_entry;
  logic [kett_pkg::ENTRY_W-1:0] rd_data;
  kett_pkg::entry_t             wr_entry;
  logic                         we;
  logic [kett_pkg::IDX_W-1:0]   waddr;

  logic                         chk_live;
  logic                         chk_match;
  logic [kett_pkg::TICK_W:0]    sum;
  logic [kett_pkg::TICK_W-1:0]  sat;
  logic                         is_tick;
  logic                         is_add;
  logic                         commit_fire;
  logic                         add_ok;
  logic                         add_restart;
  logic                         add_insert;
  kett_pkg::result_t            result_next;

  kett_ram #(
    .WIDTH (kett_pkg::ENTRY_W),
    .DEPTH (kett_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_data)
  );

  assign rd_entry    = kett_pkg::entry_t'(rd_data);
  assign is_tick     = (item.opcode == kett_pkg::OP_TICK);
  assign is_add      = (item.opcode == kett_pkg::OP_ADD);
  assign chk_live    = live[chk_idx];
  assign chk_match   = chk_valid && chk_live && (rd_entry.key == item.timer_key);

  // saturating accumulate for the tick
  assign sum = {1'b0, rd_entry.acc} + {1'b0, item.elapsed_ticks};
  assign sat = sum[kett_pkg::TICK_W] ? '1 : sum[kett_pkg::TICK_W-1:0];

  assign st.out_free  = !out_valid || out_ready;
  assign commit_fire  = cmd.commit && st.out_free;
  assign add_ok       = is_add && (item.duration != '0);
  assign add_restart  = add_ok && match_hit;
  assign add_insert   = add_ok && !match_hit && free_hit;

  always_comb begin
    we       = 1'b0;
    waddr    = chk_idx;
    wr_entry = rd_entry;
    if (chk_valid && is_tick && chk_live) begin
      we           = 1'b1;
      wr_entry.acc = sat;
    end else if (commit_fire && add_restart) begin
      we       = 1'b1;
      waddr    = match_idx;
      wr_entry = '{key: item.timer_key, acc: '0, limit: item.duration};
    end else if (commit_fire && add_insert) begin
      we       = 1'b1;
      waddr    = free_idx;
      wr_entry = '{key: item.timer_key, acc: item.start_ticks, limit: item.duration};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= item_in;
    end
    chk_idx <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= cmd.rd_en;
    end
  end

  // scan results, reset at the start of each item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
      match_idx <= '0;
      free_idx  <= '0;
      q_acc     <= '0;
      q_dur     <= '0;
    end else if (chk_valid) begin
      if (chk_match && !match_hit) begin
        match_hit <= 1'b1;
        match_idx <= chk_idx;
        q_acc     <= rd_entry.acc;
        q_dur     <= rd_entry.limit;
      end
      if (!chk_live && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= chk_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (chk_valid && is_tick && chk_live) begin
      if (sat > rd_entry.limit) begin
        live[chk_idx] <= 1'b0;
      end
    end else if (commit_fire) begin
      if (item.opcode == kett_pkg::OP_CLEAR) begin
        live <= '0;
      end else if (add_insert) begin
        live[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    result_next = '0;
    case (item.opcode)
      kett_pkg::OP_ADD: begin
        result_next.accepted   = add_restart || add_insert;
        result_next.table_full = add_ok && !match_hit && !free_hit;
      end
      kett_pkg::OP_QUERY: begin
        result_next.accepted       = 1'b1;
        result_next.found          = match_hit;
        result_next.accumulated    = match_hit ? q_acc : '0;
        result_next.entry_duration = match_hit ? q_dur : '0;
      end
      default: begin
        result_next.accepted = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      result <= result_next;
    end
  end

endmodule

### rtl/core/keyed_expiry_timer_table.sv
// top level of the keyed expiry timer table
// A table of kett_pkg::ENTRIES timers, each with a 16-bit key, accumulated
// ticks and duration. Requests arrive on req (opcode, timer_key,
// elapsed_ticks, duration, start_ticks) and each request item yields exactly
// one result item on rsp (accepted, found, table_full, accumulated,
// entry_duration). Both channels move an item when valid and ready are high.
// Opcodes: tick, add or restart, query, clear all.
// Every request scans all entries, one ram read per cycle, then passes
// through a drain state and a commit state before req.ready returns, so a new
// request is not taken until the last one is through; the single read port of
// the entry ram sets the pace of the scan. The result item is registered on
// the edge that ends the commit cycle in which the output register is free.
// req.ready is high only while the block is idle. A result waiting in the
// output register does not block the next request; if the receiver still
// holds back when the next result is due, the block waits in its commit
// cycle until the output register frees up.
// Synchronous reset empties the table (all live bits clear) and drops any
// pending result; entry contents are left as they were.
module keyed_expiry_timer_table (
  input  logic    clk,
  input  logic    rst,
  kett_req_if.sink   req,
  kett_rsp_if.source rsp
);

  kett_pkg::cmd_t    cmd;
  kett_pkg::status_t st;
  kett_pkg::item_t   item_in;
  kett_pkg::result_t result;
  logic              in_ready;
  logic              out_valid;

  assign item_in.opcode        = kett_pkg::opcode_t'(req.opcode);
  assign item_in.timer_key     = req.timer_key;
  assign item_in.elapsed_ticks = req.elapsed_ticks;
  assign item_in.duration      = req.duration;
  assign item_in.start_ticks   = req.start_ticks;
  assign req.ready             = in_ready;

  kett_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  kett_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .item_in   (item_in),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .result    (result)
  );

  assign rsp.valid          = out_valid;
  assign rsp.accepted       = result.accepted;
  assign rsp.found          = result.found;
  assign rsp.table_full     = result.table_full;
  assign rsp.accumulated    = result.accumulated;
  assign rsp.entry_duration = result.entry_duration;

endmodule

### verif/tb_top.sv
// self-checking testbench for the keyed expiry timer table
module tb_top;
  import kett_pkg::*;

  localparam int DIR_ROWS     = 23;
  localparam int RANDOM_ITEMS = 2000;
  localparam int KEY_POOL     = 32;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  localparam result_t PLAIN_OK = '{1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000};
  localparam result_t REJECTED = '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000};

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  kett_req_if req_ch ();
  kett_rsp_if rsp_ch ();

  keyed_expiry_timer_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // own copy of the timer table
  logic              slot_live  [ENTRIES];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [TICK_W-1:0] slot_acc   [ENTRIES];
  logic [TICK_W-1:0] slot_limit [ENTRIES];

  result_t           awaited_results [$];
  logic [KEY_W-1:0]  key_pool [KEY_POOL];
  row_t              directed_rows [DIR_ROWS];
  int                fill_left   = 0;
  int                req_quiet   = 0;
  int                rsp_quiet   = 0;
  int                mismatches  = 0;
  int                idle_cycles = 0;

  function automatic result_t timer_table_step(item_t it);
    result_t     r;
    int          hit;
    int          free_slot;
    logic [16:0] sum;
    r         = '0;
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_key[i] == it.timer_key && hit < 0) hit = i;
      if (!slot_live[i] && free_slot < 0) free_slot = i;
    end
    case (it.opcode)
      OP_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live[i]) begin
            sum = {1'b0, slot_acc[i]} + {1'b0, it.elapsed_ticks};
            slot_acc[i] = sum[16] ? 16'hFFFF : sum[15:0];
            if (slot_acc[i] > slot_limit[i]) slot_live[i] = 1'b0;
          end
        end
        r.accepted = 1'b1;
      end
      OP_ADD: begin
        if (it.duration != '0) begin
          if (hit >= 0) begin
            // restart ignores the start value
            slot_acc[hit]   = '0;
            slot_limit[hit] = it.duration;
            r.accepted      = 1'b1;
          end else if (free_slot >= 0) begin
            slot_live[free_slot]  = 1'b1;
            slot_key[free_slot]   = it.timer_key;
            slot_acc[free_slot]   = it.start_ticks;
            slot_limit[free_slot] = it.duration;
            r.accepted            = 1'b1;
          end else begin
            r.table_full = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        r.accepted = 1'b1;
        if (hit >= 0) begin
          r.found          = 1'b1;
          r.accumulated    = slot_acc[hit];
          r.entry_duration = slot_limit[hit];
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
        r.accepted = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic row_t stim_row(opcode_t op, logic [15:0] key, logic [15:0] elapsed,
                                    logic [15:0] dur, logic [15:0] start, bit typed,
                                    result_t want);
    row_t r;
    r.stim.opcode        = op;
    r.stim.timer_key     = key;
    r.stim.elapsed_ticks = elapsed;
    r.stim.duration      = dur;
    r.stim.start_ticks   = start;
    r.typed              = typed;
    r.want               = want;
    return r;
  endfunction

  function automatic item_t random_request();
    item_t it;
    int    pick;
    it.opcode        = opcode_t'($urandom_range(0, 3));
    it.timer_key     = 16'($urandom);
    it.elapsed_ticks = 16'($urandom);
    it.duration      = 16'($urandom);
    it.start_ticks   = 16'($urandom);
    if (fill_left > 0) begin
      // burst of fresh keys after a clear, fills the table and can run into a full one
      fill_left--;
      it.opcode      = OP_ADD;
      it.duration    = 16'($urandom_range(1000, 65535));
      it.start_ticks = 16'($urandom_range(0, 50));
    end else if ($urandom_range(0, 149) == 0) begin
      it.opcode = OP_CLEAR;
      fill_left = $urandom_range(16, 20);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      it.opcode = OP_ADD;
      else if (pick < 70) it.opcode = OP_QUERY;
      else if (pick < 96) it.opcode = OP_TICK;
      else                it.opcode = OP_CLEAR;
      if ($urandom_range(0, 99) < 85) it.timer_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 70)      it.duration = 16'($urandom_range(1, 300));
      else if (pick < 78) it.duration = 16'h0000;
      else if (pick < 85) it.duration = 16'hFFFF;
      else if (pick < 90) it.duration = 16'h0001;
      pick = $urandom_range(0, 99);
      if (pick < 60)      it.start_ticks = 16'($urandom_range(0, 100));
      else if (pick < 80) it.start_ticks = 16'h0000;
      pick = $urandom_range(0, 99);
      if (pick < 70)      it.elapsed_ticks = 16'($urandom_range(0, 60));
      else if (pick < 80) it.elapsed_ticks = 16'h0000;
      else if (pick < 90) it.elapsed_ticks = 16'hFFFF;
      if ($urandom_range(0, 199) == 0) key_pool[$urandom_range(0, KEY_POOL - 1)] = 16'($urandom);
    end
    return it;
  endfunction

  // idle cycles before the next item, with occasional stretches of none
  function automatic int idle_draw(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic send_request(item_t it, bit typed, result_t want);
    int      gap;
    result_t predicted;
    gap = idle_draw(req_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= it.opcode;
    req_ch.timer_key     <= it.timer_key;
    req_ch.elapsed_ticks <= it.elapsed_ticks;
    req_ch.duration      <= it.duration;
    req_ch.start_ticks   <= it.start_ticks;
    do @(posedge clk); while (!req_ch.ready);
    predicted = timer_table_step(it);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = '0;
    req_ch.timer_key     = '0;
    req_ch.elapsed_ticks = '0;
    req_ch.duration      = '0;
    req_ch.start_ticks   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_live[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_acc[i]   = '0;
      slot_limit[i] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = 16'($urandom);

    directed_rows[0]  = stim_row(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, PLAIN_OK);
    directed_rows[1]  = stim_row(OP_TICK,  16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1, PLAIN_OK);
    directed_rows[2]  = stim_row(OP_ADD,   16'h1234, 16'h0000, 16'h0000, 16'h0007, 1, REJECTED);
    directed_rows[3]  = stim_row(OP_QUERY, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 1, PLAIN_OK);
    directed_rows[4]  = stim_row(OP_ADD,   16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1, PLAIN_OK);
    directed_rows[5]  = stim_row(OP_TICK,  16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1, PLAIN_OK);
    // saturated entry with the longest duration stays live
    directed_rows[6]  = stim_row(OP_QUERY, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1,
                                 '{1'b1, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF});
    // start beyond duration survives until the next tick
    directed_rows[7]  = stim_row(OP_ADD,   16'h0000, 16'h0000, 16'h0005, 16'h0009, 0, REJECTED);
    directed_rows[8]  = stim_row(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, REJECTED);
    directed_rows[9]  = stim_row(OP_TICK,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, REJECTED);
    directed_rows[10] = stim_row(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, REJECTED);
    // restart of a live key
    directed_rows[11] = stim_row(OP_ADD,   16'hFFFF, 16'h0000, 16'h0003, 16'h0064, 0, REJECTED);
    directed_rows[12] = stim_row(OP_QUERY, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 0, REJECTED);
    directed_rows[13] = stim_row(OP_ADD,   16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 0, REJECTED);
    directed_rows[14] = stim_row(OP_TICK,  16'h0000, 16'h0001, 16'h0000, 16'h0000, 0, REJECTED);
    directed_rows[15] = stim_row(OP_QUERY, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 0, REJECTED);
    directed_rows[16] = stim_row(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, PLAIN_OK);
    directed_rows[17] = stim_row(OP_QUERY, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, PLAIN_OK);
    // accumulated equal to duration is kept, one more tick frees it
    directed_rows[18] = stim_row(OP_ADD,   16'h0005, 16'h0000, 16'h0001, 16'h0000, 0, REJECTED);
    directed_rows[19] = stim_row(OP_TICK,  16'h0000, 16'h0001, 16'h0000, 16'h0000, 0, REJECTED);
    directed_rows[20] = stim_row(OP_QUERY, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 0, REJECTED);
    directed_rows[21] = stim_row(OP_TICK,  16'h0000, 16'h0001, 16'h0000, 16'h0000, 0, REJECTED);
    directed_rows[22] = stim_row(OP_QUERY, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 0, REJECTED);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    for (int n = 0; n < RANDOM_ITEMS; n++) send_request(random_request(), 0, REJECTED);
    req_ch.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = idle_draw(rsp_quiet);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with no request outstanding");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0h, actual %0h", want.accepted, rsp_ch.accepted);
          mismatches++;
        end
        if (rsp_ch.found !== want.found) begin
          $error("found: expected %0h, actual %0h", want.found, rsp_ch.found);
          mismatches++;
        end
        if (rsp_ch.table_full !== want.table_full) begin
          $error("table_full: expected %0h, actual %0h", want.table_full, rsp_ch.table_full);
          mismatches++;
        end
        if (rsp_ch.accumulated !== want.accumulated) begin
          $error("accumulated: expected %0h, actual %0h", want.accumulated,
                 rsp_ch.accumulated);
          mismatches++;
        end
        if (rsp_ch.entry_duration !== want.entry_duration) begin
          $error("entry_duration: expected %0h, actual %0h", want.entry_duration,
                 rsp_ch.entry_duration);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
